/* hw/rtl/sfrb_pkg.sv */
// ----------------------------------------------------------------------------
// sfrb_pkg
// Shared constants and types for the SLIP frame ring buffer.
// ----------------------------------------------------------------------------
package sfrb_pkg;

  // Default ring depth
  localparam int unsigned DefaultDepth = 256;

  // SLIP framing bytes
  localparam logic [7:0] FEND_BYTE  = 8'hC0;
  localparam logic [7:0] FESC_BYTE  = 8'hDB;
  localparam logic [7:0] TFEND_BYTE = 8'hDC;
  localparam logic [7:0] TFESC_BYTE = 8'hDD;

  // Two delimiters around every frame
  localparam int unsigned FrameOverhead = 2;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // One result beat
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] space_left;
  } res_t;

endpackage

/* hw/rtl/slip_frame_ring_buffer_unit.sv */
// ----------------------------------------------------------------------------
// slip_frame_ring_buffer_unit
// SLIP frame builder over a byte ring held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o | command_i, data_byte_i, frame_length_i
//  out     | output    | out_valid_o/out_ready_i | status_o, read_byte_o, read_valid_o,
//          |           |                       | space_left_o
//
//  Start, end, plain payload and read-on-empty complete from the idle state; an
//  escaped payload byte makes two ring writes through the single write port
//  (the second one in S_ESC2) and a successful read waits in S_RDATA for the
//  registered memory read data. One result beat per input beat. A result that
//  cannot leave goes to a one-deep hold register; input stalls only while that
//  register is full or the sequencer is in S_ESC2 or S_RDATA.
//  Reset clears pointers, frame flags and handshake state; ring contents are
//  not cleared (only committed, already written entries are ever read).
//
module slip_frame_ring_buffer_unit
  import sfrb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DefaultDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] frame_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic [7:0] space_left_o
);

  // Pointer width and a compare width wide enough for depth and length + 2
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = ((AW > 9) ? AW : 9) + 2;

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ESC2  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  // --------------------------------------------------------------------------
  // Modular pointer helpers (depth need not be a power of two)
  // --------------------------------------------------------------------------
  function automatic logic [CW-1:0] free_of(input logic [AW-1:0] rd, input logic [AW-1:0] wr);
    logic [CW-1:0] f;
    if (rd > wr) begin
      f = CW'(rd) - CW'(wr) - CW'(1);
    end else begin
      f = CW'(rd) + CW'(BUFFER_DEPTH) - CW'(wr) - CW'(1);
    end
    return f;
  endfunction

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] p, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(p) + (AW+1)'(off);
    if (s >= (AW+1)'(BUFFER_DEPTH)) begin
      s = s - (AW+1)'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] p);
    return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [7:0] sat8(input logic [CW-1:0] v);
    return (v >= CW'(255)) ? 8'hFF : v[7:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [1:0]    state_q, state_d;
  logic [AW-1:0] wr_q, wr_d;       // committed head
  logic [AW-1:0] rd_q, rd_d;       // tail
  logic [AW-1:0] pend_q, pend_d;   // entries written in the open frame
  logic          open_q, open_d;
  logic          drop_q, drop_d;
  logic [7:0]    esc2_q, esc2_d;   // second byte of an escape pair

  // Ring memory, one write and one registered read port
  logic [7:0]    mem_q [BUFFER_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [7:0]    rdata_q;

  // Result path: output register plus one-deep hold
  res_t res, out_q, hold_q;
  logic fin;
  logic out_valid_q, hold_valid_q;
  logic out_free;

  logic          in_fire;
  logic [CW-1:0] free_cur;
  logic [AW-1:0] pend_addr;
  logic          is_esc;

  assign in_ready_o = (state_q == S_IDLE) && !hold_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign free_cur   = free_of(rd_q, wr_q);
  assign pend_addr  = add_mod(wr_q, pend_q);
  assign is_esc     = (data_byte_i == FEND_BYTE) || (data_byte_i == FESC_BYTE);

  // --------------------------------------------------------------------------
  // Command sequencer
  // Reads touch only committed entries and never share a cycle with a write,
  // so no forwarding is needed around the memory.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    pend_d    = pend_q;
    open_d    = open_q;
    drop_d    = drop_q;
    esc2_d    = esc2_q;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = FEND_BYTE;
    mem_re    = 1'b0;
    fin       = 1'b0;
    res       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (command_i)
            CMD_START: begin
              fin    = 1'b1;
              open_d = 1'b0;
              drop_d = 1'b0;
              pend_d = '0;
              if (free_cur < CW'(frame_length_i) + CW'(FrameOverhead)) begin
                res.status = ST_NOSPACE;
              end else begin
                // tentative opening delimiter at the head
                mem_we     = 1'b1;
                mem_waddr  = wr_q;
                mem_wdata  = FEND_BYTE;
                pend_d     = AW'(1);
                open_d     = 1'b1;
                res.status = ST_OK;
              end
            end
            CMD_DATA: begin
              if (!open_q) begin
                fin        = 1'b1;
                res.status = ST_IGNORED;
              end else if (drop_q) begin
                fin        = 1'b1;
                res.status = ST_NOSPACE;
              end else if (CW'(pend_q) + (is_esc ? CW'(2) : CW'(1)) + CW'(1) > free_cur) begin
                fin        = 1'b1;
                drop_d     = 1'b1;
                res.status = ST_NOSPACE;
              end else if (is_esc) begin
                mem_we    = 1'b1;
                mem_wdata = FESC_BYTE;
                pend_d    = pend_q + AW'(1);
                esc2_d    = (data_byte_i == FEND_BYTE) ? TFEND_BYTE : TFESC_BYTE;
                state_d   = S_ESC2;
              end else begin
                fin        = 1'b1;
                mem_we     = 1'b1;
                mem_wdata  = data_byte_i;
                pend_d     = pend_q + AW'(1);
                res.status = ST_OK;
              end
            end
            CMD_END: begin
              fin = 1'b1;
              if (!open_q) begin
                res.status = ST_IGNORED;
              end else if (drop_q) begin
                res.status = ST_NOSPACE;
              end else begin
                // closing delimiter, then commit the whole frame
                mem_we     = 1'b1;
                mem_wdata  = FEND_BYTE;
                wr_d       = inc_mod(pend_addr);
                res.status = ST_OK;
              end
              open_d = 1'b0;
              drop_d = 1'b0;
              pend_d = '0;
            end
            CMD_READ: begin
              if (rd_q == wr_q) begin
                fin        = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                rd_d    = inc_mod(rd_q);
                state_d = S_RDATA;
              end
            end
            default: ;
          endcase
        end
      end
      S_ESC2: begin
        mem_we     = 1'b1;
        mem_wdata  = esc2_q;
        pend_d     = pend_q + AW'(1);
        fin        = 1'b1;
        res.status = ST_OK;
        state_d    = S_IDLE;
      end
      S_RDATA: begin
        fin            = 1'b1;
        res.status     = ST_OK;
        res.read_byte  = rdata_q;
        res.read_valid = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    res.space_left = sat8(free_of(rd_d, wr_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wr_q    <= '0;
      rd_q    <= '0;
      pend_q  <= '0;
      open_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      pend_q  <= pend_d;
      open_q  <= open_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    esc2_q <= esc2_d;
  end

  // Ring memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_q];
    end
  end

  // --------------------------------------------------------------------------
  // Output register and hold (skid) register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (hold_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
      end else if (fin) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_q <= hold_q;
    end else if (fin) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign read_byte_o  = out_q.read_byte;
  assign read_valid_o = out_q.read_valid;
  assign space_left_o = out_q.space_left;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hold_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("hold register full while output register empty");

  a_busy_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !hold_valid_q)
    else $error("hold register full during a multi-cycle item");

  a_rdata_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i == CMD_READ) && (rd_q != wr_q) |=> (state_q == S_RDATA))
    else $error("read issued without data phase");

  a_closed_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (pend_q == '0) && !drop_q)
    else $error("pending entries or drop flag without an open frame");

  a_pending_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q && !drop_q |-> (CW'(pend_q) <= free_cur))
    else $error("open frame overruns committed free space");

endmodule

/* test/slip_frame_ring_buffer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_ring_buffer_unit_test
// Checks the SLIP frame ring buffer: frames are opened, filled and closed.
// Reads pop committed bytes. Every result beat is compared field by field
// with a pinned table beat or a software copy of the ring. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module slip_frame_ring_buffer_unit_test;
  import sfrb_pkg::*;

  localparam int unsigned RandomTarget = 550;

  // One directed stimulus row. When pinned is set, the typed beat is the
  // expected result; otherwise the ring predictor supplies it.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic [7:0] len;
    logic       pinned;
    res_t       beat;
  } step_row_t;

  localparam res_t NoBeat = '0;

  localparam step_row_t StepTable[25] = '{
    // fresh ring: nothing to read, nothing open, full length cannot fit
    '{CMD_READ,  8'h00, 8'd0,   1'b1, '{ST_EMPTY,   8'h00, 1'b0, 8'd255}},
    '{CMD_DATA,  8'h00, 8'd0,   1'b1, '{ST_IGNORED, 8'h00, 1'b0, 8'd255}},
    '{CMD_END,   8'h00, 8'd0,   1'b1, '{ST_IGNORED, 8'h00, 1'b0, 8'd255}},
    '{CMD_START, 8'h00, 8'd255, 1'b1, '{ST_NOSPACE, 8'h00, 1'b0, 8'd255}},
    // largest length that still fits; opening does not consume space yet
    '{CMD_START, 8'h00, 8'd253, 1'b1, '{ST_OK,      8'h00, 1'b0, 8'd255}},
    '{CMD_DATA,  8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hFF, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hC0, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hDB, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'h55, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hAA, 8'd0,   1'b0, NoBeat},
    '{CMD_END,   8'h00, 8'd0,   1'b0, NoBeat},
    // start over an open frame abandons it
    '{CMD_START, 8'h00, 8'd4,   1'b0, NoBeat},
    '{CMD_DATA,  8'h12, 8'd0,   1'b0, NoBeat},
    '{CMD_START, 8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hDC, 8'd0,   1'b0, NoBeat},
    '{CMD_DATA,  8'hDD, 8'd0,   1'b0, NoBeat},
    '{CMD_END,   8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_READ,  8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_READ,  8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_READ,  8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_READ,  8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_READ,  8'h00, 8'd0,   1'b0, NoBeat},
    // empty frame: two delimiters only
    '{CMD_START, 8'h00, 8'd0,   1'b0, NoBeat},
    '{CMD_END,   8'h00, 8'd0,   1'b0, NoBeat}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] command_i;
  logic [7:0] data_byte_i;
  logic [7:0] frame_length_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [7:0] read_byte_o;
  logic       read_valid_o;
  logic [7:0] space_left_o;

  // Pinned expectation travels with the input beat it belongs to.
  logic hold_pinned;
  res_t hold_beat;

  // Ring shadow
  logic [7:0] ring_bytes [DefaultDepth];
  logic [7:0] head_ptr;
  logic [7:0] tail_ptr;
  int         frame_fill;
  bit         in_frame;
  bit         frame_lost;

  res_t expected_beats[$];
  int   mismatches;
  int   useful_beats;
  bit   idle_on;

  always #4 clk_i = ~clk_i;

  slip_frame_ring_buffer_unit #(
    .BUFFER_DEPTH(DefaultDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .frame_length_i(frame_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_byte_o   (read_byte_o),
    .read_valid_o  (read_valid_o),
    .space_left_o  (space_left_o)
  );

  // --------------------------------------------------------------------------
  // Ring predictor
  // --------------------------------------------------------------------------

  // Committed free entries; one slot stays empty to tell full from empty.
  function automatic int committed_room();
    logic [7:0] room;
    room = tail_ptr - head_ptr - 8'd1;
    return int'(room);
  endfunction

  // Staged bytes sit past the committed head until the frame closes.
  function automatic void stage_byte(logic [7:0] b);
    logic [7:0] idx;
    idx = head_ptr + 8'(frame_fill);
    ring_bytes[idx] = b;
    frame_fill++;
  endfunction

  function automatic res_t slip_ring_step(logic [1:0] cmd, logic [7:0] data,
                                          logic [7:0] len);
    res_t r;
    bit   esc;
    int   need;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_START: begin
        in_frame   = 1'b0;
        frame_lost = 1'b0;
        frame_fill = 0;
        if (committed_room() < int'(len) + int'(FrameOverhead)) begin
          r.status = ST_NOSPACE;
        end else begin
          stage_byte(FEND_BYTE);
          in_frame = 1'b1;
        end
      end
      CMD_DATA: begin
        if (!in_frame) begin
          r.status = ST_IGNORED;
        end else if (frame_lost) begin
          r.status = ST_NOSPACE;
        end else begin
          esc  = (data == FEND_BYTE) || (data == FESC_BYTE);
          need = esc ? 2 : 1;
          // payload must leave room for the closing delimiter
          if (frame_fill + need + 1 > committed_room()) begin
            frame_lost = 1'b1;
            r.status   = ST_NOSPACE;
          end else if (esc) begin
            stage_byte(FESC_BYTE);
            stage_byte(data == FEND_BYTE ? TFEND_BYTE : TFESC_BYTE);
          end else begin
            stage_byte(data);
          end
        end
      end
      CMD_END: begin
        if (!in_frame) begin
          r.status = ST_IGNORED;
        end else if (frame_lost) begin
          r.status = ST_NOSPACE;
        end else begin
          stage_byte(FEND_BYTE);
          head_ptr = head_ptr + 8'(frame_fill);
        end
        in_frame   = 1'b0;
        frame_lost = 1'b0;
        frame_fill = 0;
      end
      default: begin
        if (tail_ptr == head_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_byte  = ring_bytes[tail_ptr];
          r.read_valid = 1'b1;
          tail_ptr     = tail_ptr + 8'd1;
        end
      end
    endcase
    r.space_left = 8'(committed_room());
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: input beats feed the predictor, output beats are checked
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    res_t pred;
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pred = slip_ring_step(command_i, data_byte_i, frame_length_i);
        expected_beats.push_back(hold_pinned ? hold_beat : pred);
        if (pred.status != ST_IGNORED) useful_beats++;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, read_byte_o, read_valid_o, space_left_o};
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: status %0d read_byte %0h", status_o, read_byte_o);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.read_byte !== want.read_byte) begin
            $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte);
            mismatches++;
          end
          if (got.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0d, got %0d", want.read_valid, got.read_valid);
            mismatches++;
          end
          if (got.space_left !== want.space_left) begin
            $error("space_left: expected %0d, got %0d", want.space_left, got.space_left);
            mismatches++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Drives one input beat at the falling edge and holds it until taken.
  task automatic push_beat(logic [1:0] cmd, logic [7:0] data, logic [7:0] len,
                           logic pinned, res_t beat);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    data_byte_i    <= data;
    frame_length_i <= len;
    hold_pinned    <= pinned;
    hold_beat      <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic push_random(logic [1:0] cmd);
    push_beat(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, NoBeat);
  endtask

  // Payload byte, biased toward the two bytes that need escaping.
  function automatic logic [7:0] pick_payload(int esc_pct);
    if ($urandom_range(0, 99) < esc_pct) return $urandom_range(0, 1) ? FEND_BYTE : FESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Start, payload, optional end. Announced length usually matches.
  task automatic send_frame(int nbytes, int esc_pct, bit close);
    logic [7:0] len;
    if ($urandom_range(0, 9) < 7) len = 8'(nbytes > 255 ? 255 : nbytes);
    else len = 8'($urandom_range(0, 255));
    push_beat(CMD_START, 8'($urandom_range(0, 255)), len, 1'b0, NoBeat);
    for (int i = 0; i < nbytes; i++) begin
      push_beat(CMD_DATA, pick_payload(esc_pct), 8'($urandom_range(0, 255)), 1'b0, NoBeat);
    end
    if (close) push_random(CMD_END);
  endtask

  // Result side: random stall before each beat, ready held until taken.
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 16) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    bit filling;
    int phase_end;
    int pick;
    int read_pct;
    int nbytes;
    bit long_frame;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_READ;
    data_byte_i    = '0;
    frame_length_i = '0;
    hold_pinned    = 1'b0;
    hold_beat      = NoBeat;
    head_ptr       = '0;
    tail_ptr       = '0;
    frame_fill     = 0;
    in_frame       = 1'b0;
    frame_lost     = 1'b0;
    mismatches     = 0;
    useful_beats   = 0;
    idle_on        = 1'b1;
    foreach (ring_bytes[i]) ring_bytes[i] = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (StepTable[i]) begin
      push_beat(StepTable[i].cmd, StepTable[i].data, StepTable[i].len,
                StepTable[i].pinned, StepTable[i].beat);
    end

    // Alternate fill phases (frames, few reads) with drain phases so the
    // ring runs near full, where start checks fail and escapes overrun.
    filling   = 1'b1;
    phase_end = useful_beats + 200;
    while (useful_beats < RandomTarget) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if (useful_beats >= phase_end) begin
        filling   = !filling;
        phase_end = useful_beats + (filling ? 200 : 120);
      end
      pick     = $urandom_range(0, 99);
      read_pct = filling ? 10 : 45;
      if (pick < read_pct) begin
        repeat ($urandom_range(1, filling ? 4 : 40)) push_random(CMD_READ);
      end else if (pick < read_pct + 10) begin
        // noise: any command, any content
        repeat ($urandom_range(1, 6)) push_random(2'($urandom_range(0, 3)));
      end else if (pick < read_pct + 17) begin
        // broken frame left open; the next item decides its fate
        send_frame($urandom_range(0, 8), 20, 1'b0);
      end else begin
        long_frame = ($urandom_range(0, 24) == 0);
        nbytes = long_frame ? $urandom_range(150, 200)
                            : $urandom_range(0, filling ? 24 : 10);
        send_frame(nbytes, long_frame ? 50 : 20, 1'b1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (16) @(posedge clk_i);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
